// ===== sv/ard_pkg.sv =====
package ard_pkg;

   typedef enum logic [3:0] {
      PH_COUNT_LO = 4'd0,
      PH_COUNT_HI = 4'd1,
      PH_NAME_LEN = 4'd2,
      PH_NAME     = 4'd3,
      PH_SIZE0    = 4'd4,
      PH_SIZE1    = 4'd5,
      PH_SIZE2    = 4'd6,
      PH_DATA     = 4'd7,
      PH_TRAIL    = 4'd8
   } phase_type;

   localparam logic [1:0] OP_BYTE = 2'd0;
   localparam logic [1:0] OP_LAST = 2'd1;
   localparam logic [1:0] OP_END  = 2'd2;

   localparam logic [2:0] KIND_COUNT   = 3'd0;
   localparam logic [2:0] KIND_NAMELEN = 3'd1;
   localparam logic [2:0] KIND_NAME    = 3'd2;
   localparam logic [2:0] KIND_SIZE    = 3'd3;
   localparam logic [2:0] KIND_DATA    = 3'd4;
   localparam logic [2:0] KIND_TRAIL   = 3'd5;
   localparam logic [2:0] KIND_NONE    = 3'd6;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] in_byte;
   } ard_req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [2:0]  byte_kind;
      logic [15:0] entry_number;
      logic        field_end;
      logic [23:0] field_length;
      logic        entry_done;
      logic        archive_done;
      logic        status;
   } ard_rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  count_low;
      logic [15:0] entries_left;
      logic [15:0] current_entry;
      logic [23:0] field_remaining;
      logic [15:0] size_partial;
   } ard_state_type;

   localparam ard_state_type ARD_STATE_RESET = '{
      phase:           PH_COUNT_LO,
      count_low:       8'd0,
      entries_left:    16'd0,
      current_entry:   16'd0,
      field_remaining: 24'd0,
      size_partial:    16'd0
   };

endpackage

// ===== sv/ard_decode.sv =====
module ard_decode
   import ard_pkg::*;
(
   input  ard_state_type cur,
   input  ard_req_type   req,
   output ard_state_type nxt,
   output ard_rsp_type   rsp
);

   logic [15:0] count_value;
   logic [23:0] size_value;
   logic [23:0] remaining_dec;
   logic [15:0] entries_dec;
   logic [15:0] entry_inc;
   logic        has_byte;

   assign count_value   = {req.in_byte, cur.count_low};
   assign size_value    = {req.in_byte, cur.size_partial};
   assign remaining_dec = cur.field_remaining - 24'd1;
   assign entries_dec   = cur.entries_left - 16'd1;
   assign entry_inc     = cur.current_entry + 16'd1;
   assign has_byte      = (req.opcode == OP_BYTE) || (req.opcode == OP_LAST);

   always_comb begin
      nxt = cur;
      rsp = '0;
      rsp.byte_kind = KIND_NONE;
      if (has_byte) begin
         rsp.out_byte     = req.in_byte;
         rsp.entry_number = cur.current_entry;
         case (cur.phase)
            PH_COUNT_HI: begin
               rsp.byte_kind     = KIND_COUNT;
               rsp.entry_number  = 16'd0;
               rsp.field_end     = 1'b1;
               rsp.field_length  = {8'd0, count_value};
               nxt.entries_left  = count_value;
               nxt.current_entry = 16'd0;
               if (count_value == 16'd0) begin
                  rsp.archive_done = 1'b1;
                  nxt.phase        = PH_TRAIL;
               end else begin
                  nxt.phase = PH_NAME_LEN;
               end
            end
            PH_NAME_LEN: begin
               rsp.byte_kind    = KIND_NAMELEN;
               rsp.field_end    = 1'b1;
               rsp.field_length = {16'd0, req.in_byte};
               if (req.in_byte == 8'd0) begin
                  nxt.phase = PH_SIZE0;
               end else begin
                  nxt.field_remaining = {16'd0, req.in_byte};
                  nxt.phase           = PH_NAME;
               end
            end
            PH_NAME: begin
               rsp.byte_kind       = KIND_NAME;
               nxt.field_remaining = remaining_dec;
               if (remaining_dec == 24'd0) begin
                  rsp.field_end = 1'b1;
                  nxt.phase     = PH_SIZE0;
               end
            end
            PH_SIZE0: begin
               rsp.byte_kind    = KIND_SIZE;
               nxt.size_partial = {8'd0, req.in_byte};
               nxt.phase        = PH_SIZE1;
            end
            PH_SIZE1: begin
               rsp.byte_kind    = KIND_SIZE;
               nxt.size_partial = {req.in_byte, cur.size_partial[7:0]};
               nxt.phase        = PH_SIZE2;
            end
            PH_SIZE2: begin
               rsp.byte_kind    = KIND_SIZE;
               rsp.field_end    = 1'b1;
               rsp.field_length = size_value;
               if (size_value == 24'd0) begin
                  // empty data field closes the entry right here
                  rsp.entry_done    = 1'b1;
                  nxt.entries_left  = entries_dec;
                  nxt.current_entry = entry_inc;
                  if (entries_dec == 16'd0) begin
                     rsp.archive_done = 1'b1;
                     nxt.phase        = PH_TRAIL;
                  end else begin
                     nxt.phase = PH_NAME_LEN;
                  end
               end else begin
                  nxt.field_remaining = size_value;
                  nxt.phase           = PH_DATA;
               end
            end
            PH_DATA: begin
               rsp.byte_kind       = KIND_DATA;
               nxt.field_remaining = remaining_dec;
               if (remaining_dec == 24'd0) begin
                  rsp.field_end     = 1'b1;
                  rsp.entry_done    = 1'b1;
                  nxt.entries_left  = entries_dec;
                  nxt.current_entry = entry_inc;
                  if (entries_dec == 16'd0) begin
                     rsp.archive_done = 1'b1;
                     nxt.phase        = PH_TRAIL;
                  end else begin
                     nxt.phase = PH_NAME_LEN;
                  end
               end
            end
            PH_TRAIL: begin
               rsp.byte_kind = KIND_TRAIL;
            end
            default: begin
               rsp.byte_kind    = KIND_COUNT;
               rsp.entry_number = 16'd0;
               nxt.count_low    = req.in_byte;
               nxt.phase        = PH_COUNT_HI;
            end
         endcase
         if (req.opcode == OP_LAST) begin
            rsp.status = (nxt.phase != PH_TRAIL);
            nxt        = ARD_STATE_RESET;
         end
      end else begin
         // end of buffer with no word, unused opcode included
         rsp.status = (cur.phase != PH_TRAIL);
         nxt        = ARD_STATE_RESET;
      end
   end

endmodule

// ===== sv/archive_record_deframer_unit.sv =====
// Archive record deframer. Takes one buffer byte per word and returns one tagged result
// word per input word, in order. Throughput is one word per clock cycle without stalls;
// a word passes the input register, then the result register. The parse state is
// updated once per word in the single decode stage between the two registers, so
// consecutive bytes flow without gaps. rsp_ready low stalls the result register and
// then the input register; req_ready stays high while either can still move.
module archive_record_deframer_unit
   import ard_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ard_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ard_rsp_type rsp_data
);

   logic          req_valid_ff;
   ard_req_type   req_data_ff;
   logic          rsp_valid_ff;
   ard_rsp_type   rsp_data_ff;
   ard_state_type state_ff;
   ard_state_type state_in;
   ard_rsp_type   rsp_data_in;
   logic          advance;

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   ard_decode u_decode (
      .cur (state_ff),
      .req (req_data_ff),
      .nxt (state_in),
      .rsp (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ARD_STATE_RESET;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/ard_checker.sv =====
module ard_checker
   import ard_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input ard_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input ard_rsp_type rsp_data
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word right after reset");

   // an empty end-of-buffer word carries only status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_kind == KIND_NONE |->
         rsp_data.out_byte == 8'd0 && rsp_data.entry_number == 16'd0 &&
         rsp_data.field_length == 24'd0 && !rsp_data.field_end &&
         !rsp_data.entry_done && !rsp_data.archive_done)
      else $error("end word carries payload");

   // archive completion comes with an entry completion or a zero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.archive_done |->
         rsp_data.entry_done ||
         (rsp_data.byte_kind == KIND_COUNT && rsp_data.field_length == 24'd0))
      else $error("archive done without entry done");

   // an entry completes only on the end of a size or data field
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entry_done |->
         rsp_data.field_end &&
         (rsp_data.byte_kind == KIND_SIZE || rsp_data.byte_kind == KIND_DATA))
      else $error("entry done off a field end");

endmodule

bind archive_record_deframer_unit ard_checker u_ard_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import ard_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int END_ON_LAST = 0;
   localparam int END_WORD    = 1;
   localparam int END_UNUSED  = 2;
   localparam int WORDS_PER_PHASE = 180;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ard_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ard_rsp_type rsp_data;

   ard_req_type pending_words[$];
   ard_rsp_type expected_tags[$];

   int send_gap_pct = 0;
   int stall_pct = 0;
   int words_queued = 0;
   int tags_checked = 0;
   int mismatches = 0;
   int archives_built = 0;
   int archives_closed = 0;
   int truncations = 0;

   // parse state of the predictor
   phase_type   walk_phase;
   logic [7:0]  count_lo;
   logic [15:0] entries_todo;
   logic [15:0] entry_idx;
   logic [23:0] bytes_todo;
   logic [15:0] size_lo;

   archive_record_deframer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   function void restart_walk();
      walk_phase   = PH_COUNT_LO;
      count_lo     = '0;
      entries_todo = '0;
      entry_idx    = '0;
      bytes_todo   = '0;
      size_lo      = '0;
   endfunction

   function ard_rsp_type tag_byte(ard_req_type w);
      ard_rsp_type t;
      logic [15:0] cnt;
      logic [23:0] sz;
      logic        closes;
      t = '0;
      t.byte_kind = KIND_NONE;
      closes = 1'b0;
      if (w.opcode == OP_END || w.opcode == OP_UNUSED) begin
         t.status = (walk_phase != PH_TRAIL);
         restart_walk();
      end else begin
         t.out_byte = w.in_byte;
         t.entry_number = entry_idx;
         case (walk_phase)
            PH_COUNT_HI: begin
               cnt = {w.in_byte, count_lo};
               t.byte_kind = KIND_COUNT;
               t.entry_number = '0;
               t.field_end = 1'b1;
               t.field_length = {8'd0, cnt};
               entries_todo = cnt;
               entry_idx = '0;
               // an empty archive is complete on its count
               if (cnt == 16'd0) begin
                  t.archive_done = 1'b1;
                  walk_phase = PH_TRAIL;
               end else begin
                  walk_phase = PH_NAME_LEN;
               end
            end
            PH_NAME_LEN: begin
               t.byte_kind = KIND_NAMELEN;
               t.field_end = 1'b1;
               t.field_length = {16'd0, w.in_byte};
               if (w.in_byte == 8'd0) begin
                  walk_phase = PH_SIZE0;
               end else begin
                  bytes_todo = {16'd0, w.in_byte};
                  walk_phase = PH_NAME;
               end
            end
            PH_NAME: begin
               t.byte_kind = KIND_NAME;
               bytes_todo = bytes_todo - 24'd1;
               if (bytes_todo == 24'd0) begin
                  t.field_end = 1'b1;
                  walk_phase = PH_SIZE0;
               end
            end
            PH_SIZE0: begin
               t.byte_kind = KIND_SIZE;
               size_lo = {8'd0, w.in_byte};
               walk_phase = PH_SIZE1;
            end
            PH_SIZE1: begin
               t.byte_kind = KIND_SIZE;
               size_lo[15:8] = w.in_byte;
               walk_phase = PH_SIZE2;
            end
            PH_SIZE2: begin
               sz = {w.in_byte, size_lo};
               t.byte_kind = KIND_SIZE;
               t.field_end = 1'b1;
               t.field_length = sz;
               if (sz == 24'd0) begin
                  closes = 1'b1;
               end else begin
                  bytes_todo = sz;
                  walk_phase = PH_DATA;
               end
            end
            PH_DATA: begin
               t.byte_kind = KIND_DATA;
               bytes_todo = bytes_todo - 24'd1;
               if (bytes_todo == 24'd0) begin
                  t.field_end = 1'b1;
                  closes = 1'b1;
               end
            end
            PH_TRAIL: begin
               t.byte_kind = KIND_TRAIL;
            end
            default: begin
               t.byte_kind = KIND_COUNT;
               t.entry_number = '0;
               count_lo = w.in_byte;
               walk_phase = PH_COUNT_HI;
            end
         endcase
         if (closes) begin
            t.entry_done = 1'b1;
            entries_todo = entries_todo - 16'd1;
            entry_idx = entry_idx + 16'd1;
            if (entries_todo == 16'd0) begin
               t.archive_done = 1'b1;
               walk_phase = PH_TRAIL;
            end else begin
               walk_phase = PH_NAME_LEN;
            end
         end
         if (w.opcode == OP_LAST) begin
            t.status = (walk_phase != PH_TRAIL);
            restart_walk();
         end
      end
      return t;
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [23:0] got, logic [23:0] want);
      if (got !== want)
         report_mismatch($sformatf("word %0d %s got 0x%0h want 0x%0h",
                                   tags_checked, name, got, want));
   endtask

   task automatic push_word(logic [1:0] op, logic [7:0] b);
      pending_words = {pending_words, ard_req_type'{opcode: op, in_byte: b}};
      words_queued++;
   endtask

   // builds one archive; a count above the built entries leaves it unfinished
   task automatic send_archive(int count_field, int entries, int max_name, int max_data,
                               int trail, bit cut, int end_style);
      logic [7:0] q[$];
      int n;
      int sz;
      int keep;
      q = {q, count_field[7:0]};
      q = {q, count_field[15:8]};
      for (int e = 0; e < entries; e++) begin
         n = $urandom_range(max_name, 0);
         q = {q, n[7:0]};
         repeat (n) q = {q, 8'($urandom)};
         sz = $urandom_range(max_data, 0);
         q = {q, sz[7:0]};
         q = {q, sz[15:8]};
         q = {q, sz[23:16]};
         repeat (sz) q = {q, 8'($urandom)};
      end
      if (cut) begin
         keep = $urandom_range(q.size() - 1, 0);
         while (q.size() > keep) void'(q.pop_back());
      end else begin
         repeat (trail) q = {q, 8'($urandom)};
      end
      for (int i = 0; i < q.size(); i++) begin
         if (end_style == END_ON_LAST && i == q.size() - 1)
            push_word(OP_LAST, q[i]);
         else
            push_word(OP_BYTE, q[i]);
      end
      if (end_style == END_UNUSED)
         push_word(OP_UNUSED, 8'($urandom));
      else if (end_style == END_WORD || q.size() == 0)
         push_word(OP_END, 8'($urandom));
      archives_built++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         restart_walk();
      end else begin
         if (req_valid && req_ready)
            expected_tags = {expected_tags, tag_byte(req_data)};
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      ard_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tags.size() == 0) begin
               report_mismatch($sformatf("unexpected result word %p", rsp_data));
            end else begin
               want = expected_tags.pop_front();
               check_field("out_byte", 24'(rsp_data.out_byte), 24'(want.out_byte));
               check_field("byte_kind", 24'(rsp_data.byte_kind), 24'(want.byte_kind));
               check_field("entry_number", 24'(rsp_data.entry_number),
                           24'(want.entry_number));
               check_field("field_end", 24'(rsp_data.field_end), 24'(want.field_end));
               check_field("field_length", rsp_data.field_length, want.field_length);
               check_field("entry_done", 24'(rsp_data.entry_done), 24'(want.entry_done));
               check_field("archive_done", 24'(rsp_data.archive_done),
                           24'(want.archive_done));
               check_field("status", 24'(rsp_data.status), 24'(want.status));
               tags_checked++;
               if (want.archive_done) archives_closed++;
               if (want.status) truncations++;
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= stall_pct);
      end
   end

   initial begin
      int sel;
      int cnt;
      int target;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // end of an empty buffer
      push_word(OP_END, 8'hA5);
      // count of zero, then a trailing byte
      push_word(OP_BYTE, 8'h00);
      push_word(OP_BYTE, 8'h00);
      push_word(OP_BYTE, 8'hFF);
      push_word(OP_END, 8'h00);
      // one entry with empty name and empty data, closed on the final byte
      push_word(OP_BYTE, 8'h01);
      push_word(OP_BYTE, 8'h00);
      push_word(OP_BYTE, 8'h00);
      push_word(OP_BYTE, 8'h00);
      push_word(OP_BYTE, 8'h00);
      push_word(OP_LAST, 8'h00);
      // largest count and name length, cut short by the unused opcode
      push_word(OP_BYTE, 8'hFF);
      push_word(OP_BYTE, 8'hFF);
      push_word(OP_BYTE, 8'hFF);
      push_word(OP_BYTE, 8'h5A);
      push_word(OP_UNUSED, 8'hC3);
      // largest data size, buffer ends inside the data
      push_word(OP_BYTE, 8'h01);
      push_word(OP_BYTE, 8'h00);
      push_word(OP_BYTE, 8'h01);
      push_word(OP_BYTE, 8'h41);
      push_word(OP_BYTE, 8'hFF);
      push_word(OP_BYTE, 8'hFF);
      push_word(OP_BYTE, 8'hFF);
      push_word(OP_LAST, 8'h7E);
      while (pending_words.size() != 0) @(negedge clock);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 45; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 45; end
            default: begin send_gap_pct = 32; stall_pct = 32; end
         endcase
         target = words_queued + WORDS_PER_PHASE;
         while (words_queued < target) begin
            sel = $urandom_range(99, 0);
            if (sel < 60) begin
               cnt = $urandom_range(4, 0);
               send_archive(cnt, cnt, 6, 8, $urandom_range(3, 0), 1'b0,
                            $urandom_range(END_UNUSED, END_ON_LAST));
            end else if (sel < 75) begin
               cnt = $urandom_range(4, 0);
               send_archive(cnt, cnt, 6, 8, 0, 1'b1,
                            $urandom_range(END_UNUSED, END_ON_LAST));
            end else if (sel < 83) begin
               // count well past what is sent
               send_archive($urandom_range(65535, 1), 1, 20, 6, 0, 1'b0,
                            $urandom_range(END_UNUSED, END_ON_LAST));
               // random count and size headers, data runs out
            end else if (sel < 90) begin
               cnt = $urandom_range(65535, 1);
               push_word(OP_BYTE, cnt[7:0]);
               push_word(OP_BYTE, cnt[15:8]);
               push_word(OP_BYTE, 8'h00);
               repeat (3) push_word(OP_BYTE, 8'($urandom));
               repeat ($urandom_range(4, 0)) push_word(OP_BYTE, 8'($urandom));
               push_word(OP_END, 8'($urandom));
            end else begin
               repeat ($urandom_range(10, 1)) begin
                  if ($urandom_range(9, 0) < 7)
                     push_word(OP_BYTE, 8'($urandom));
                  else
                     push_word(2'($urandom_range(3, 1)), 8'($urandom));
               end
            end
         end
         while (pending_words.size() != 0) @(negedge clock);
      end

      while (pending_words.size() != 0 || req_valid || expected_tags.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);

      $display("checked %0d result words from %0d generated archives and noise runs",
               tags_checked, archives_built);
      $display("archives completed: %0d, truncated buffers flagged: %0d",
               archives_closed, truncations);
      if (mismatches == 0)
         $display("** archive_record_deframer_unit: PASSED **");
      else
         $display("** archive_record_deframer_unit: FAILED **");
      $finish;
   end

   initial begin
      #3_600_000;
      $display("timeout: %0d words still pending, %0d results outstanding",
               pending_words.size(), expected_tags.size());
      $display("** archive_record_deframer_unit: FAILED **");
      $finish;
   end

endmodule

// ===== archive_record_deframer_unit.f =====
sv/ard_pkg.sv
sv/ard_decode.sv
sv/archive_record_deframer_unit.sv
sv/ard_checker.sv
verif/tb.sv
